/* src/lelr_pkg.sv */
// Shared constants, payload words and control types of the line-evicting log ring.
package lelr_pkg;

  localparam int STORE_DEPTH = 4096;
  localparam int PTR_W       = $clog2(STORE_DEPTH);
  localparam int OFFS_W      = 12;
  localparam int FILL_W      = 12;
  localparam int CMP_W       = (PTR_W > OFFS_W) ? PTR_W : OFFS_W;

  localparam logic [7:0] LINE_END  = 8'h0A;
  localparam logic       OP_APPEND = 1'b0;
  localparam logic       OP_READ   = 1'b1;

  typedef struct packed {
    logic              op;
    logic [7:0]        data_byte;
    logic [OFFS_W-1:0] read_offset;
  } lelr_in_t;

  typedef struct packed {
    logic [7:0]        read_byte;
    logic              in_range;
    logic [FILL_W-1:0] fill_length;
    logic              line_dropped;
  } lelr_out_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK_RD,
    ST_WALK_CHK
  } lelr_state_t;

  typedef struct packed {
    logic accept;
    logic walk_issue;
    logic walk_check;
    logic finish;
  } lelr_cmd_t;

  typedef struct packed {
    logic evict_hit;
    logic walk_nl;
    logic walk_last;
  } lelr_stat_t;

endpackage

/* src/lelr_ctrl.sv */
// Controller state machine: accepts words and sequences the eviction walk.
module lelr_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  lelr_pkg::lelr_stat_t stat,
  output lelr_pkg::lelr_cmd_t  cmd
);
  import lelr_pkg::*;

  lelr_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start && stat.evict_hit) begin
          state_nxt = ST_WALK_RD;
        end
      end
      ST_WALK_RD: begin
        state_nxt = ST_WALK_CHK;
      end
      ST_WALK_CHK: begin
        if (stat.walk_nl || stat.walk_last) begin
          state_nxt = ST_IDLE;
        end else begin
          state_nxt = ST_WALK_RD;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    busy = 1'b1;
    cmd  = '0;
    unique case (state_r)
      ST_IDLE: begin
        busy       = 1'b0;
        cmd.accept = start;
        cmd.finish = start && !stat.evict_hit;
      end
      ST_WALK_RD: begin
        cmd.walk_issue = 1'b1;
      end
      ST_WALK_CHK: begin
        cmd.walk_check = 1'b1;
        cmd.finish     = stat.walk_nl || stat.walk_last;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

endmodule

/* src/lelr_dp.sv */
// Datapath: byte store, ring pointers, walk pointer and result register.
module lelr_dp (
  input  logic                 clk,
  input  logic                 rst_n,
  input  lelr_pkg::lelr_in_t   in_word,
  input  lelr_pkg::lelr_cmd_t  cmd,
  output lelr_pkg::lelr_stat_t stat,
  output logic                 out_strobe,
  output lelr_pkg::lelr_out_t  out_word
);
  import lelr_pkg::*;

  logic [7:0]       mem [STORE_DEPTH];
  logic [PTR_W-1:0] wp_r, wp_nxt;
  logic [PTR_W-1:0] oldest_r, oldest_nxt;
  logic [PTR_W-1:0] walk_r, walk_nxt;
  logic [7:0]       rd_data_r;
  logic             inr_r, inr_nxt;
  logic             drop_r, drop_nxt;
  logic             strobe_r;

  logic [PTR_W-1:0] fill;
  logic [CMP_W-1:0] fill_ext;
  logic [CMP_W-1:0] offs_ext;
  logic             offs_ok;
  logic             is_append;
  logic             wr_en;
  logic             rd_en;
  logic [PTR_W-1:0] rd_addr;
  logic [PTR_W-1:0] wp_inc;
  logic [PTR_W-1:0] walk_inc;

  always_comb begin
    fill      = wp_r - oldest_r;
    fill_ext  = CMP_W'(fill);
    offs_ext  = CMP_W'(in_word.read_offset);
    offs_ok   = offs_ext < fill_ext;
    is_append = (in_word.op == OP_APPEND);
    wp_inc    = wp_r + PTR_W'(1);
    walk_inc  = walk_r + PTR_W'(1);

    stat.evict_hit = is_append && (wp_inc == oldest_r);
    stat.walk_nl   = (rd_data_r == LINE_END);
    stat.walk_last = (walk_inc == wp_r);

    wr_en   = cmd.accept && is_append;
    rd_en   = (cmd.accept && !is_append && offs_ok) || cmd.walk_issue;
    rd_addr = cmd.walk_issue ? walk_r : oldest_r + offs_ext[PTR_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wp_r] <= in_word.data_byte;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_comb begin
    wp_nxt     = wp_r;
    oldest_nxt = oldest_r;
    walk_nxt   = walk_r;
    inr_nxt    = inr_r;
    drop_nxt   = drop_r;
    if (cmd.accept) begin
      if (is_append) begin
        wp_nxt   = wp_inc;
        inr_nxt  = 1'b0;
        drop_nxt = stat.evict_hit;
        walk_nxt = oldest_r;
      end else begin
        inr_nxt  = offs_ok;
        drop_nxt = 1'b0;
      end
    end
    if (cmd.walk_check) begin
      if (stat.walk_nl) begin
        oldest_nxt = walk_inc;
      end else if (stat.walk_last) begin
        oldest_nxt = oldest_r + PTR_W'(1);
      end else begin
        walk_nxt = walk_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r     <= '0;
      oldest_r <= '0;
      inr_r    <= 1'b0;
      drop_r   <= 1'b0;
      strobe_r <= 1'b0;
    end else begin
      wp_r     <= wp_nxt;
      oldest_r <= oldest_nxt;
      inr_r    <= inr_nxt;
      drop_r   <= drop_nxt;
      strobe_r <= cmd.finish;
    end
  end

  always_ff @(posedge clk) begin
    walk_r <= walk_nxt;
  end

  always_comb begin
    out_strobe            = strobe_r;
    out_word.read_byte    = inr_r ? rd_data_r : 8'h00;
    out_word.in_range     = inr_r;
    out_word.fill_length  = fill_ext[FILL_W-1:0];
    out_word.line_dropped = drop_r;
  end

endmodule

/* src/line_evicting_log_ring.sv */
// Top level of the line-evicting log ring: controller plus datapath.
//
// A circular byte log. A word is taken at a rising edge with start high and
// busy low. An append word stores data_byte at the write pointer; when the
// ring fills, the oldest whole line (up to and including the next newline)
// is dropped, or only the oldest byte if the ring holds no newline. A read
// word returns the byte read_offset bytes past the oldest stored byte, an
// in-range flag and the fill length.
// Each word yields one result word on out_word, marked by out_strobe for one
// cycle, in the cycle after the word is taken (or after the eviction walk).
// Throughput is one word per cycle while busy is low, since the memory read
// is registered and the result is shown from registers while the next word
// enters. An append that fills the ring raises busy for the eviction walk,
// which for each scanned byte does a memory read, then a newline test, until
// it meets a newline or the newest stored byte.
// Reset clears both ring pointers, so the ring starts empty; the store itself
// is not cleared and needs no clearing pass. The receiver cannot stall.
module line_evicting_log_ring (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  lelr_pkg::lelr_in_t  in_word,
  output logic                out_strobe,
  output lelr_pkg::lelr_out_t out_word
);
  import lelr_pkg::*;

  lelr_cmd_t  cmd;
  lelr_stat_t stat;

  lelr_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  lelr_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_word    (in_word),
    .cmd        (cmd),
    .stat       (stat),
    .out_strobe (out_strobe),
    .out_word   (out_word)
  );

endmodule
